// ===== rtl/pddm_pkg.sv =====
// Package for the parity-declustered disk mapper.
// Holds command, status and register codes, datapath operation codes
// and the status struct shared by the controller and the datapath.
package pddm_pkg;

   localparam int REQ_W      = 40;
   localparam int RSP_W      = 40;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;
   localparam int DIVD_W     = 44;
   localparam int DIVS_W     = 32;

   localparam logic [1:0] CMD_MAP_DATA   = 2'd0;
   localparam logic [1:0] CMD_MAP_PARITY = 2'd1;
   localparam logic [1:0] CMD_CHARGE     = 2'd2;
   localparam logic [1:0] CMD_RESTORE    = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_OVF   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_DISK_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STRIPE_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PARITY_UNITS = 2'd2;

   localparam logic [5:0]  RST_DISK_COUNT   = 6'd8;
   localparam logic [5:0]  RST_STRIPE_WIDTH = 6'd4;
   localparam logic [4:0]  RST_PARITY_UNITS = 5'd1;
   localparam logic [31:0] RST_QUOTA        = 32'd140;
   localparam logic [6:0]  LEVEL_LIMIT      = 7'd64;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_BIN_TOP,
      OP_BIN_UNR,
      OP_MUL,
      OP_BRES_ZERO,
      OP_BRES_R,
      OP_DIV_R,
      OP_DIV_COMMIT,
      OP_SET_BCG,
      OP_STATUS1,
      OP_STATUS2,
      OP_DIV_IDX,
      OP_SAVE_QOFF,
      OP_DIV_Q,
      OP_SAVE_RANK,
      OP_UNR_INIT,
      OP_UNR_NEXT_L,
      OP_UNR_NEXT_I,
      OP_DISK,
      OP_RMUL1,
      OP_RMUL2,
      OP_DIV_RST,
      OP_RESTORE,
      OP_CHARGE,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       lt;
      logic       n_gt_k;
      logic       mul_ovf;
      logic       d_gt1;
      logic       rem_zero;
      logic       div_busy;
      logic       bovf;
      logic       p_ge_g;
      logic       bcg_zero;
      logic       c_zero;
      logic       sec_ge_g;
      logic       v_gt_rank;
      logic       pos_hit;
      logic       i_is1;
      logic       l_max;
      logic       rsp_stall;
   } dp_stat_type;

endpackage

// ===== rtl/pddm_div.sv =====
// Radix-2 restoring divider, two quotient bits per cycle.
// Uses pddm_pkg for operand widths.
module pddm_div
   import pddm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output logic              busy,
   output logic [DIVD_W-1:0] quotient,
   output logic [DIVS_W-1:0] remainder
);

   localparam int STEPS = DIVD_W / 2;

   logic              busy_ff, busy_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] dvs_ff, dvs_in;

   always_comb begin
      logic [DIVS_W:0]   sh;
      logic [DIVS_W-1:0] rv;
      logic [DIVD_W-1:0] qv;
      rv = rem_ff;
      qv = quo_ff;
      for (int s = 0; s < 2; s++) begin
         sh = {rv, qv[DIVD_W-1]};
         qv = {qv[DIVD_W-2:0], 1'b0};
         if (sh >= {1'b0, dvs_ff}) begin
            sh = sh - {1'b0, dvs_ff};
            qv[0] = 1'b1;
         end
         rv = sh[DIVS_W-1:0];
      end
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'(STEPS);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = qv;
         rem_in = rv;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/pddm_ctrl.sv =====
// Controller state machine of the disk mapper.
// Sequences binomial, division and unranking steps; uses pddm_pkg.
module pddm_ctrl
   import pddm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  dp_stat_type stat,
   output dp_op_type   op
);

   typedef enum logic [20:0] {
      S_IDLE     = 21'h000001,
      S_DISPATCH = 21'h000002,
      S_B_MUL    = 21'h000004,
      S_B_IDIV   = 21'h000008,
      S_B_IWAIT  = 21'h000010,
      S_B_TDIV   = 21'h000020,
      S_B_TWAIT  = 21'h000040,
      S_B_RET    = 21'h000080,
      S_T_DISP   = 21'h000100,
      S_M_W1     = 21'h000200,
      S_M_D2     = 21'h000400,
      S_M_W2     = 21'h000800,
      S_M_CHK    = 21'h001000,
      S_U_BIN    = 21'h002000,
      S_R_MUL1   = 21'h004000,
      S_R_MUL2   = 21'h008000,
      S_R_DIV    = 21'h010000,
      S_R_WAIT   = 21'h020000,
      S_R_WRITE  = 21'h040000,
      S_CHARGE   = 21'h080000,
      S_FIN      = 21'h100000
   } state_type;

   state_type state_ff, state_in;
   logic      unr_ff, unr_in;

   always_comb begin
      state_in = state_ff;
      unr_in   = unr_ff;
      op       = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op       = OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.cmd == CMD_CHARGE) begin
               state_in = S_CHARGE;
            end else begin
               op       = OP_BIN_TOP;
               unr_in   = 1'b0;
               state_in = S_B_MUL;
            end
         end
         S_B_MUL: begin
            if (stat.lt) begin
               op       = OP_BRES_ZERO;
               state_in = S_B_RET;
            end else if (stat.n_gt_k) begin
               op       = OP_MUL;
               state_in = stat.mul_ovf ? S_B_RET : S_B_IDIV;
            end else begin
               state_in = S_B_TDIV;
            end
         end
         S_B_IDIV: begin
            if (stat.d_gt1) begin
               op       = OP_DIV_R;
               state_in = S_B_IWAIT;
            end else begin
               state_in = S_B_MUL;
            end
         end
         S_B_IWAIT: begin
            if (!stat.div_busy) begin
               if (stat.rem_zero) begin
                  op       = OP_DIV_COMMIT;
                  state_in = S_B_IDIV;
               end else begin
                  state_in = S_B_MUL;
               end
            end
         end
         S_B_TDIV: begin
            if (stat.d_gt1) begin
               op       = OP_DIV_R;
               state_in = S_B_TWAIT;
            end else begin
               op       = OP_BRES_R;
               state_in = S_B_RET;
            end
         end
         S_B_TWAIT: begin
            if (!stat.div_busy) begin
               op       = OP_DIV_COMMIT;
               state_in = S_B_TDIV;
            end
         end
         S_B_RET: begin
            if (!unr_ff) begin
               op       = OP_SET_BCG;
               state_in = S_T_DISP;
            end else if (stat.bovf) begin
               op       = OP_STATUS2;
               state_in = S_FIN;
            end else if (stat.v_gt_rank) begin
               if (stat.pos_hit) begin
                  op       = OP_DISK;
                  state_in = S_FIN;
               end else if (stat.i_is1) begin
                  state_in = S_FIN;
               end else begin
                  op       = OP_UNR_NEXT_I;
                  state_in = S_U_BIN;
               end
            end else if (stat.l_max) begin
               op       = OP_STATUS2;
               state_in = S_FIN;
            end else begin
               op       = OP_UNR_NEXT_L;
               state_in = S_U_BIN;
            end
         end
         S_T_DISP: begin
            if (stat.cmd == CMD_RESTORE) begin
               state_in = S_R_MUL1;
            end else if (stat.p_ge_g) begin
               op       = OP_STATUS1;
               state_in = S_FIN;
            end else if (stat.bcg_zero) begin
               op       = OP_STATUS2;
               state_in = S_FIN;
            end else begin
               op       = OP_DIV_IDX;
               state_in = S_M_W1;
            end
         end
         S_M_W1: begin
            if (!stat.div_busy) begin
               op       = OP_SAVE_QOFF;
               state_in = S_M_D2;
            end
         end
         S_M_D2: begin
            op       = OP_DIV_Q;
            state_in = S_M_W2;
         end
         S_M_W2: begin
            if (!stat.div_busy) begin
               op       = OP_SAVE_RANK;
               state_in = S_M_CHK;
            end
         end
         S_M_CHK: begin
            if (stat.sec_ge_g) begin
               op       = OP_STATUS1;
               state_in = S_FIN;
            end else begin
               op       = OP_UNR_INIT;
               state_in = S_U_BIN;
            end
         end
         S_U_BIN: begin
            op       = OP_BIN_UNR;
            unr_in   = 1'b1;
            state_in = S_B_MUL;
         end
         S_R_MUL1: begin
            op       = OP_RMUL1;
            state_in = S_R_MUL2;
         end
         S_R_MUL2: begin
            op       = OP_RMUL2;
            state_in = S_R_DIV;
         end
         S_R_DIV: begin
            if (stat.c_zero) begin
               state_in = S_R_WRITE;
            end else begin
               op       = OP_DIV_RST;
               state_in = S_R_WAIT;
            end
         end
         S_R_WAIT: begin
            if (!stat.div_busy) begin
               state_in = S_R_WRITE;
            end
         end
         S_R_WRITE: begin
            op       = OP_RESTORE;
            state_in = S_FIN;
         end
         S_CHARGE: begin
            op       = OP_CHARGE;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!stat.rsp_stall) begin
               op       = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         unr_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         unr_ff   <= unr_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !reset;

endmodule

// ===== rtl/pddm_dp.sv =====
// Datapath of the disk mapper: configuration, operand registers,
// binomial multiplier, quota counters and result register. Uses pddm_pkg and pddm_div.
module pddm_dp
   import pddm_pkg::*;
#(
   parameter int MAX_DISKS = 32
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_op_type            op,
   output dp_stat_type          stat,
   input  logic [REQ_W-1:0]     req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IW = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;

   logic [5:0]  c_ff, g_ff;
   logic [4:0]  p_ff;

   logic [1:0]  cmd_ff, cmd_in;
   logic [30:0] idx_ff, idx_in;
   logic [4:0]  tgt_ff, tgt_in;
   logic [6:0]  n_ff, n_in, k_ff, k_in;
   logic [5:0]  d_ff, d_in;
   logic        lt_ff, lt_in;
   logic [31:0] r_ff, r_in, bres_ff, bres_in, bcg_ff, bcg_in;
   logic        bovf_ff, bovf_in;
   logic [30:0] q_ff, q_in, sec_ff, sec_in;
   logic [5:0]  off_ff, off_in, pos_ff, pos_in, i_ff, i_in;
   logic [31:0] rank_ff, rank_in, prev_ff, prev_in;
   logic [6:0]  l_ff, l_in;
   logic [4:0]  disk_ff, disk_in;
   logic [1:0]  status_ff, status_in;
   logic [43:0] t_ff, t_in;
   logic [31:0] quota_ff [MAX_DISKS];
   logic [31:0] quota_in [MAX_DISKS];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [5:0]        w;
   logic [32:0]       rp1;
   logic [39:0]       prod;
   logic              mul_ovf;
   logic [6:0]        src_n, src_k, diff;
   logic              swap;
   logic              div_start, div_busy;
   logic [DIVD_W-1:0] div_dvd, div_quo;
   logic [DIVS_W-1:0] div_dvs, div_rem;
   logic              tgt_ok;
   logic [IW-1:0]     tgt_ix;
   logic [31:0]       quota_rd;

   assign w       = g_ff - {1'b0, p_ff};
   assign rp1     = {1'b0, r_ff} + 33'd1;
   assign prod    = 40'(rp1) * 40'(n_ff);
   assign mul_ovf = |prod[39:32];
   assign src_n   = (op == OP_BIN_TOP) ? {1'b0, c_ff} : l_ff;
   assign src_k   = (op == OP_BIN_TOP) ? {1'b0, g_ff} : {1'b0, i_ff};
   assign diff    = src_n - src_k;
   assign swap    = diff > src_k;
   assign tgt_ok  = {1'b0, tgt_ff} < 6'(MAX_DISKS);
   assign tgt_ix  = tgt_ff[IW-1:0];
   assign quota_rd = tgt_ok ? quota_ff[tgt_ix] : '0;

   always_comb begin
      div_start = 1'b1;
      case (op)
         OP_DIV_R: begin
            div_dvd = 44'(r_ff);
            div_dvs = 32'(d_ff);
         end
         OP_DIV_IDX: begin
            div_dvd = 44'(idx_ff);
            div_dvs = 32'(w);
         end
         OP_DIV_Q: begin
            div_dvd = 44'(q_ff);
            div_dvs = bcg_ff;
         end
         OP_DIV_RST: begin
            div_dvd = t_ff;
            div_dvs = 32'(c_ff);
         end
         default: begin
            div_start = 1'b0;
            div_dvd   = t_ff;
            div_dvs   = 32'(c_ff);
         end
      endcase
   end

   pddm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      logic [6:0] sum;
      sum          = 7'(sec_ff[5:0]) + 7'(off_ff);
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      tgt_in       = tgt_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      d_in         = d_ff;
      lt_in        = lt_ff;
      r_in         = r_ff;
      bres_in      = bres_ff;
      bovf_in      = bovf_ff;
      bcg_in       = bcg_ff;
      q_in         = q_ff;
      sec_in       = sec_ff;
      off_in       = off_ff;
      pos_in       = pos_ff;
      i_in         = i_ff;
      l_in         = l_ff;
      rank_in      = rank_ff;
      prev_in      = prev_ff;
      disk_in      = disk_ff;
      status_in    = status_ff;
      t_in         = t_ff;
      quota_in     = quota_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (op)
         OP_LOAD: begin
            cmd_in    = req_tdata[1:0];
            idx_in    = req_tdata[32:2];
            tgt_in    = req_tdata[37:33];
            disk_in   = '0;
            status_in = ST_OK;
         end
         OP_BIN_TOP, OP_BIN_UNR: begin
            n_in    = src_n;
            lt_in   = src_n < src_k;
            k_in    = swap ? diff : src_k;
            d_in    = swap ? src_k[5:0] : diff[5:0];
            r_in    = 32'd1;
            bovf_in = 1'b0;
         end
         OP_MUL: begin
            if (mul_ovf) begin
               bovf_in = 1'b1;
               bres_in = '0;
            end else begin
               r_in = prod[31:0] - 32'(n_ff);
               n_in = n_ff - 7'd1;
            end
         end
         OP_BRES_ZERO: bres_in = '0;
         OP_BRES_R:    bres_in = r_ff;
         OP_DIV_COMMIT: begin
            r_in = div_quo[31:0];
            d_in = d_ff - 6'd1;
         end
         OP_SET_BCG: bcg_in = bres_ff;
         OP_STATUS1: begin
            status_in = ST_RANGE;
            disk_in   = '0;
         end
         OP_STATUS2: begin
            status_in = ST_OVF;
            disk_in   = '0;
         end
         OP_SAVE_QOFF: begin
            q_in   = div_quo[30:0];
            off_in = div_rem[5:0];
         end
         OP_SAVE_RANK: begin
            rank_in = div_rem;
            sec_in  = div_quo[30:0];
         end
         OP_UNR_INIT: begin
            if (cmd_ff == CMD_MAP_DATA) begin
               pos_in = (sum >= 7'(w)) ? off_ff + 6'(p_ff) : off_ff;
            end else begin
               pos_in = g_ff - sec_ff[5:0] - 6'd1;
            end
            i_in    = g_ff;
            l_in    = {1'b0, g_ff};
            prev_in = '0;
         end
         OP_UNR_NEXT_L: begin
            prev_in = bres_ff;
            l_in    = l_ff + 7'd1;
         end
         OP_UNR_NEXT_I: begin
            rank_in = rank_ff - prev_ff;
            i_in    = i_ff - 6'd1;
            l_in    = {1'b0, i_ff - 6'd1};
            prev_in = '0;
         end
         OP_DISK:  disk_in = 5'(l_ff - 7'd1);
         OP_RMUL1: t_in = 44'(bcg_ff) * 44'(g_ff);
         OP_RMUL2: t_in = t_ff * 44'(g_ff);
         OP_RESTORE: begin
            status_in = (bcg_ff == '0) ? ST_OVF : ST_OK;
            for (int j = 0; j < MAX_DISKS; j++) begin
               if (6'(j) < c_ff) begin
                  quota_in[j] = (c_ff == '0) ? '0 : div_quo[31:0];
               end
            end
         end
         OP_CHARGE: begin
            if (tgt_ok) begin
               quota_in[tgt_ix] = quota_ff[tgt_ix] - 32'd1;
            end
         end
         OP_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {1'b0, status_ff, quota_rd, disk_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff         <= RST_DISK_COUNT;
         g_ff         <= RST_STRIPE_WIDTH;
         p_ff         <= RST_PARITY_UNITS;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < MAX_DISKS; j++) begin
            quota_ff[j] <= RST_QUOTA;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_DISK_COUNT:   c_ff <= csr_wdata;
               REG_STRIPE_WIDTH: g_ff <= csr_wdata;
               REG_PARITY_UNITS: p_ff <= csr_wdata[4:0];
               default: begin
               end
            endcase
         end
         rsp_valid_ff <= rsp_valid_in;
         quota_ff     <= quota_in;
      end
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      tgt_ff      <= tgt_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      d_ff        <= d_in;
      lt_ff       <= lt_in;
      r_ff        <= r_in;
      bres_ff     <= bres_in;
      bovf_ff     <= bovf_in;
      bcg_ff      <= bcg_in;
      q_ff        <= q_in;
      sec_ff      <= sec_in;
      off_ff      <= off_in;
      pos_ff      <= pos_in;
      i_ff        <= i_in;
      l_ff        <= l_in;
      rank_ff     <= rank_in;
      prev_ff     <= prev_in;
      disk_ff     <= disk_in;
      status_ff   <= status_in;
      t_ff        <= t_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      stat.cmd       = cmd_ff;
      stat.lt        = lt_ff;
      stat.n_gt_k    = n_ff > k_ff;
      stat.mul_ovf   = mul_ovf;
      stat.d_gt1     = d_ff > 6'd1;
      stat.rem_zero  = div_rem == '0;
      stat.div_busy  = div_busy;
      stat.bovf      = bovf_ff;
      stat.p_ge_g    = {1'b0, p_ff} >= g_ff;
      stat.bcg_zero  = bcg_ff == '0;
      stat.c_zero    = c_ff == '0;
      stat.sec_ge_g  = sec_ff >= 31'(g_ff);
      stat.v_gt_rank = bres_ff > rank_ff;
      stat.pos_hit   = pos_ff == (i_ff - 6'd1);
      stat.i_is1     = i_ff == 6'd1;
      stat.l_max     = l_ff == LEVEL_LIMIT;
      stat.rsp_stall = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/parity_declustered_disk_mapper.sv =====
// Top level of the parity-declustered disk mapper.
// Joins pddm_ctrl and pddm_dp; uses pddm_pkg.
//
//   channel  dir  transfer on            payload
//   req      in   req_tvalid&req_tready  tdata: command, unit_index, target_disk
//   rsp      out  rsp_tvalid&rsp_tready  tdata: mapped_disk, disk_quota, status
//   csr      in   csr_we                 csr_index, csr_wdata
//
// One item at a time. Restore and map run every binomial multiply in the
// multiplier and every division in the shared divider; a map also runs
// the unranking search.
// Reset is synchronous; quotas reset to 140, registers to C=8, G=4, P=1.
// A held result stalls only the final load of the next one.
module parity_declustered_disk_mapper
   import pddm_pkg::*;
#(
   parameter int MAX_DISKS = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,  // command[1:0], unit_index[32:2], target_disk[37:33]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,  // mapped_disk[4:0], disk_quota[36:5], status[38:37]
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_op_type   op;
   dp_stat_type stat;

   pddm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .op         (op)
   );

   pddm_dp #(
      .MAX_DISKS (MAX_DISKS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

// ===== rtl/pddm_checker.sv =====
// Port-level checks for the disk mapper, bound to the top level.
// Uses pddm_pkg for widths and status codes.
module pddm_checker
   import pddm_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[38:37] != 2'd3)
      else $error("undefined status code");

   a_fail_disk: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[38:37] != ST_OK |-> rsp_tdata[4:0] == 5'd0)
      else $error("failed map reports a disk");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transfer taken while busy");

endmodule

bind parity_declustered_disk_mapper pddm_checker u_pddm_checker (.*);
